/* design/byte_ring_buffer_defines.svh */
// Assertion macros shared by the byte ring buffer design files.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef BYTE_RING_BUFFER_DEFINES_SVH
`define BYTE_RING_BUFFER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BRB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define BRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/brb_pkg.sv */
// Package for the byte ring buffer: fixed field widths, request codes and
// the control record passed from the request stage to the merge stage.
package brb_pkg;

  localparam int BYTE_W     = 8;
  localparam int NUM_FIELDS = 8;
  localparam int LEN_W      = 4;
  localparam int FILL_W     = 11;
  localparam int CFG_W      = 4;
  localparam int BANK_IDX_W = 3;

  localparam logic [CFG_W-1:0] CAP_LOG2_RESET = 4'd10;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic                  accepted;
    logic [FILL_W-1:0]     fill_level;
    logic                  pop_ok;
    logic [LEN_W-1:0]      len;
    logic [BANK_IDX_W-1:0] base_lo;
    logic [BANK_IDX_W-1:0] mask_lo;
  } rd_ctl_t;

endpackage

/* design/byte_ring_buffer.sv */
// Top level of the byte ring buffer: request decode, index and count state,
// banked byte lanes and the merge stage. Depends on brb_pkg, brb_bank, brb_merge.
//
// Usage. Each input transfer is a push or a pop of 0 to LANES bytes and gives
// exactly one result transfer: accepted, fill_level and the popped bytes in
// order (zero in unused fields). A push that does not fit and a pop asking for
// more bytes than are stored are refused whole; a zero length is accepted.
// cfg_wr_data sets log2 of the capacity in use, saturated at the largest power
// of two not above DEPTH; write it only while no transfer is in flight.
// A transfer is registered in the read stage, then in the merge stage. One item
// per cycle is taken while out_stall holds no result: the store has one bank per
// byte lane, so a push writes and a pop reads all lanes in one memory access.
// A synchronous reset clears the indices, the count and both pipeline valids
// and sets the capacity to 1024; stored bytes are not cleared. When out_stall
// holds a result, one more item can sit in the read stage, after which
// in_stall rises until the result is taken.
`include "byte_ring_buffer_defines.svh"

module byte_ring_buffer #(
  parameter int DEPTH = 1024,
  parameter int LANES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [brb_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [brb_pkg::LEN_W-1:0]     in_length,
  input  logic [brb_pkg::BYTE_W-1:0]    in_data_in_0,
  input  logic [brb_pkg::BYTE_W-1:0]    in_data_in_1,
  input  logic [brb_pkg::BYTE_W-1:0]    in_data_in_2,
  input  logic [brb_pkg::BYTE_W-1:0]    in_data_in_3,
  input  logic [brb_pkg::BYTE_W-1:0]    in_data_in_4,
  input  logic [brb_pkg::BYTE_W-1:0]    in_data_in_5,
  input  logic [brb_pkg::BYTE_W-1:0]    in_data_in_6,
  input  logic [brb_pkg::BYTE_W-1:0]    in_data_in_7,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_accepted,
  output logic [brb_pkg::FILL_W-1:0]    out_fill_level,
  output logic [brb_pkg::BYTE_W-1:0]    out_data_out_0,
  output logic [brb_pkg::BYTE_W-1:0]    out_data_out_1,
  output logic [brb_pkg::BYTE_W-1:0]    out_data_out_2,
  output logic [brb_pkg::BYTE_W-1:0]    out_data_out_3,
  output logic [brb_pkg::BYTE_W-1:0]    out_data_out_4,
  output logic [brb_pkg::BYTE_W-1:0]    out_data_out_5,
  output logic [brb_pkg::BYTE_W-1:0]    out_data_out_6,
  output logic [brb_pkg::BYTE_W-1:0]    out_data_out_7
);

  localparam int ADDR_W  = $clog2(DEPTH + 1) - 1;
  localparam int CAP_MAX = 2 ** ADDR_W;
  localparam int BANK_W  = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int BANKS   = 2 ** BANK_W;
  localparam int IW      = ((ADDR_W > BANK_W) ? ADDR_W : BANK_W) + 1;
  localparam int CW      = ADDR_W + 1;
  localparam int CMP_W   = ((CW > brb_pkg::LEN_W) ? CW : brb_pkg::LEN_W) + 1;

  logic [brb_pkg::CFG_W-1:0] cap_log2_r;
  logic [IW-1:0]             rd_idx_r, rd_idx_nxt;
  logic [IW-1:0]             wr_idx_r, wr_idx_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic                      s1_valid_r, s1_valid_nxt;
  brb_pkg::rd_ctl_t          s1_ctl_r, s1_ctl_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic [4:0]                eff_log2;
  logic [CW-1:0]             cap_val;
  logic [IW-1:0]             mask;
  logic                      in_acc;
  logic                      s1_adv;
  logic                      len_zero;
  logic                      len_ok;
  logic [CMP_W-1:0]          cnt_x, len_x, cap_x;
  logic                      push_ok;
  logic                      pop_ok;
  logic                      acc_now;
  logic [IW-1:0]             base;
  logic [IW-1:0]             next_idx;

  brb_pkg::byte_t            din_all [brb_pkg::NUM_FIELDS];
  brb_pkg::byte_t            lane_data [BANKS];
  brb_pkg::byte_t            bank_q [BANKS];
  brb_pkg::byte_t            data_r [brb_pkg::NUM_FIELDS];

  assign eff_log2 = ({1'b0, cap_log2_r} > 5'(ADDR_W)) ? 5'(ADDR_W) : {1'b0, cap_log2_r};
  assign cap_val  = CW'(1) << eff_log2;
  assign mask     = IW'(cap_val) - IW'(1);

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  assign len_zero = in_length == '0;
  assign len_ok   = in_length <= brb_pkg::LEN_W'(LANES);
  assign cnt_x    = CMP_W'(cnt_r);
  assign len_x    = CMP_W'(in_length);
  assign cap_x    = CMP_W'(cap_val);
  assign push_ok  = in_acc && !len_zero && len_ok && (in_req_type == brb_pkg::REQ_PUSH)
                    && ((cnt_x + len_x) <= cap_x);
  assign pop_ok   = in_acc && !len_zero && len_ok && (in_req_type == brb_pkg::REQ_POP)
                    && (len_x <= cnt_x);
  assign acc_now  = len_zero || push_ok || pop_ok;

  assign base     = ((in_req_type == brb_pkg::REQ_POP) ? rd_idx_r : wr_idx_r) & mask;
  assign next_idx = (base + IW'(in_length)) & mask;

  always_comb begin
    rd_idx_nxt = rd_idx_r;
    wr_idx_nxt = wr_idx_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_idx_nxt = next_idx;
      cnt_nxt    = cnt_r + CW'(in_length);
    end else if (pop_ok) begin
      rd_idx_nxt = next_idx;
      cnt_nxt    = cnt_r - CW'(in_length);
    end
  end

  always_comb begin
    s1_ctl_nxt.accepted   = acc_now;
    s1_ctl_nxt.fill_level = brb_pkg::FILL_W'(cnt_nxt);
    s1_ctl_nxt.pop_ok     = pop_ok;
    s1_ctl_nxt.len        = in_length;
    s1_ctl_nxt.base_lo    = brb_pkg::BANK_IDX_W'(base[BANK_W-1:0]);
    s1_ctl_nxt.mask_lo    = brb_pkg::BANK_IDX_W'(mask[BANK_W-1:0]);
  end

  always_comb begin
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_log2_r  <= brb_pkg::CAP_LOG2_RESET;
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      cnt_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_log2_r <= cfg_wr_data;
      end
      rd_idx_r    <= rd_idx_nxt;
      wr_idx_r    <= wr_idx_nxt;
      cnt_r       <= cnt_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ctl_r <= s1_ctl_nxt;
    end
  end

  assign din_all[0] = in_data_in_0;
  assign din_all[1] = in_data_in_1;
  assign din_all[2] = in_data_in_2;
  assign din_all[3] = in_data_in_3;
  assign din_all[4] = in_data_in_4;
  assign din_all[5] = in_data_in_5;
  assign din_all[6] = in_data_in_6;
  assign din_all[7] = in_data_in_7;

  for (genvar b = 0; b < BANKS; b++) begin : g_lane
    assign lane_data[b] = din_all[b];

    brb_bank #(
      .BANK   (b),
      .BANK_W (BANK_W),
      .IW     (IW)
    ) u_bank (
      .clk       (clk),
      .push_ok   (push_ok),
      .rd_en     (in_acc),
      .base      (base),
      .mask      (mask),
      .len       (in_length),
      .lane_data (lane_data),
      .rd_data_r (bank_q[b])
    );
  end

  brb_merge #(
    .BANK_W (BANK_W)
  ) u_merge (
    .clk          (clk),
    .load         (s1_adv),
    .ctl          (s1_ctl_r),
    .bank_q       (bank_q),
    .accepted_r   (out_accepted),
    .fill_level_r (out_fill_level),
    .data_r       (data_r)
  );

  assign out_valid      = out_valid_r;
  assign out_data_out_0 = data_r[0];
  assign out_data_out_1 = data_r[1];
  assign out_data_out_2 = data_r[2];
  assign out_data_out_3 = data_r[3];
  assign out_data_out_4 = data_r[4];
  assign out_data_out_5 = data_r[5];
  assign out_data_out_6 = data_r[6];
  assign out_data_out_7 = data_r[7];

  `BRB_ASSERT_IMPL(a_count_bound, 1'b1, cnt_r <= CW'(CAP_MAX),
    "stored byte count exceeds the largest capacity")
  `BRB_ASSERT_NEXT(a_push_count, rst_n && push_ok,
    cnt_r == ($past(cnt_r) + CW'($past(in_length))),
    "accepted push did not raise the count by its length")
  `BRB_ASSERT_NEXT(a_refused_hold, rst_n && in_acc && !acc_now,
    (cnt_r == $past(cnt_r)) && (rd_idx_r == $past(rd_idx_r)) && (wr_idx_r == $past(wr_idx_r)),
    "refused transfer changed the buffer state")

endmodule

/* design/brb_bank.sv */
// One byte lane of the ring store: a bank memory holding every address whose
// low bits equal the bank number. Depends on brb_pkg.
module brb_bank #(
  parameter int BANK   = 0,
  parameter int BANK_W = 3,
  parameter int IW     = 11
) (
  input  logic                    clk,
  input  logic                    push_ok,
  input  logic                    rd_en,
  input  logic [IW-1:0]           base,
  input  logic [IW-1:0]           mask,
  input  logic [brb_pkg::LEN_W-1:0] len,
  input  brb_pkg::byte_t          lane_data [2**BANK_W],
  output brb_pkg::byte_t          rd_data_r
);

  localparam int ROW_W = IW - BANK_W;

  brb_pkg::byte_t     mem [2**ROW_W];
  logic [BANK_W-1:0]  bank_id;
  logic [BANK_W-1:0]  mask_lo;
  logic [BANK_W-1:0]  off;
  logic               in_cap;
  logic [IW-1:0]      addr;
  logic [ROW_W-1:0]   row;
  logic               wr_en;

  assign bank_id = BANK_W'(BANK);
  assign mask_lo = mask[BANK_W-1:0];
  assign off     = (bank_id - base[BANK_W-1:0]) & mask_lo;
  assign in_cap  = (bank_id & ~mask_lo) == '0;
  assign addr    = (base + IW'(off)) & mask;
  assign row     = addr[IW-1:BANK_W];
  assign wr_en   = push_ok && in_cap && (brb_pkg::LEN_W'(off) < len);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[row] <= lane_data[off];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[row];
    end
  end

endmodule

/* design/brb_merge.sv */
// Merge stage: rotates the bank read data into result order, zeroes unused
// fields and registers the result item. Depends on brb_pkg.
module brb_merge #(
  parameter int BANK_W = 3
) (
  input  logic             clk,
  input  logic             load,
  input  brb_pkg::rd_ctl_t ctl,
  input  brb_pkg::byte_t   bank_q [2**BANK_W],
  output logic             accepted_r,
  output logic [brb_pkg::FILL_W-1:0] fill_level_r,
  output brb_pkg::byte_t   data_r [brb_pkg::NUM_FIELDS]
);

  brb_pkg::byte_t data_nxt [brb_pkg::NUM_FIELDS];

  always_comb begin
    logic [brb_pkg::BANK_IDX_W-1:0] sel;
    for (int i = 0; i < brb_pkg::NUM_FIELDS; i++) begin
      sel = (ctl.base_lo + brb_pkg::BANK_IDX_W'(i)) & ctl.mask_lo;
      if (ctl.pop_ok && (brb_pkg::LEN_W'(i) < ctl.len)) begin
        data_nxt[i] = bank_q[sel[BANK_W-1:0]];
      end else begin
        data_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      accepted_r   <= ctl.accepted;
      fill_level_r <= ctl.fill_level;
      data_r       <= data_nxt;
    end
  end

endmodule

/* sim/tb_byte_ring_buffer.sv */
// Testbench for byte_ring_buffer: directed and random push and pop traffic,
// checked against a predictor of the ring state. Depends on brb_pkg and the RTL.
module tb_byte_ring_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH = 1024;
  localparam int RING_DEPTH_LOG2 = 10;
  localparam int NUM_LANES = 8;

  typedef struct packed {
    logic                      req;
    logic [brb_pkg::LEN_W-1:0] len;
    brb_pkg::byte_t [7:0]      data;
  } ring_req_t;

  typedef struct packed {
    logic                       accepted;
    logic [brb_pkg::FILL_W-1:0] fill;
    brb_pkg::byte_t [7:0]       bytes;
  } ring_result_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [brb_pkg::CFG_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_req_type = brb_pkg::REQ_PUSH;
  logic [brb_pkg::LEN_W-1:0] in_length = '0;
  brb_pkg::byte_t in_data_in_0 = '0, in_data_in_1 = '0, in_data_in_2 = '0, in_data_in_3 = '0;
  brb_pkg::byte_t in_data_in_4 = '0, in_data_in_5 = '0, in_data_in_6 = '0, in_data_in_7 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_accepted;
  logic [brb_pkg::FILL_W-1:0] out_fill_level;
  brb_pkg::byte_t out_data_out_0, out_data_out_1, out_data_out_2, out_data_out_3;
  brb_pkg::byte_t out_data_out_4, out_data_out_5, out_data_out_6, out_data_out_7;

  byte_ring_buffer DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_length(in_length),
    .in_data_in_0(in_data_in_0),
    .in_data_in_1(in_data_in_1),
    .in_data_in_2(in_data_in_2),
    .in_data_in_3(in_data_in_3),
    .in_data_in_4(in_data_in_4),
    .in_data_in_5(in_data_in_5),
    .in_data_in_6(in_data_in_6),
    .in_data_in_7(in_data_in_7),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_accepted(out_accepted),
    .out_fill_level(out_fill_level),
    .out_data_out_0(out_data_out_0),
    .out_data_out_1(out_data_out_1),
    .out_data_out_2(out_data_out_2),
    .out_data_out_3(out_data_out_3),
    .out_data_out_4(out_data_out_4),
    .out_data_out_5(out_data_out_5),
    .out_data_out_6(out_data_out_6),
    .out_data_out_7(out_data_out_7)
  );

  brb_pkg::byte_t ring_mem [RING_DEPTH];
  bit ring_written [RING_DEPTH];
  int rd_ptr = 0;
  int wr_ptr = 0;
  int fill_count = 0;
  logic [brb_pkg::CFG_W-1:0] cap_log2_shadow = brb_pkg::CAP_LOG2_RESET;

  ring_result_t ring_outcomes [$];
  int error_count = 0;
  int gap_pct = 10;
  int stall_pct = 10;
  int stall_left = 0;
  bit quiet = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int ring_capacity();
    int eff;
    eff = (cap_log2_shadow > RING_DEPTH_LOG2) ? RING_DEPTH_LOG2 : cap_log2_shadow;
    return 1 << eff;
  endfunction

  function automatic bit pop_is_safe(int len);
    int mask;
    int idx;
    int k;
    mask = ring_capacity() - 1;
    if (len == 0 || len > NUM_LANES || len > fill_count) return 1'b1;
    idx = rd_ptr & mask;
    for (k = 0; k < len; k++) begin
      if (!ring_written[idx]) return 1'b0;
      idx = (idx + 1) & mask;
    end
    return 1'b1;
  endfunction

  function automatic ring_result_t apply_ring_request(ring_req_t rq);
    ring_result_t res;
    int mask;
    int idx;
    int k;
    res = '0;
    mask = ring_capacity() - 1;
    if (rq.len == 0) begin
      res.accepted = 1'b1;
    end else if (rq.len <= NUM_LANES) begin
      if (rq.req == brb_pkg::REQ_PUSH) begin
        if (fill_count + rq.len <= mask + 1) begin
          idx = wr_ptr & mask;
          for (k = 0; k < rq.len; k++) begin
            ring_mem[idx] = rq.data[k];
            ring_written[idx] = 1'b1;
            idx = (idx + 1) & mask;
          end
          wr_ptr = idx;
          fill_count += rq.len;
          res.accepted = 1'b1;
        end
      end else if (rq.len <= fill_count) begin
        idx = rd_ptr & mask;
        for (k = 0; k < rq.len; k++) begin
          res.bytes[k] = ring_mem[idx];
          idx = (idx + 1) & mask;
        end
        rd_ptr = idx;
        fill_count -= rq.len;
        res.accepted = 1'b1;
      end
    end
    res.fill = fill_count[brb_pkg::FILL_W-1:0];
    return res;
  endfunction

  function automatic ring_req_t make_req(logic req, int len, int pattern);
    ring_req_t rq;
    int k;
    rq.req = req;
    rq.len = len[brb_pkg::LEN_W-1:0];
    for (k = 0; k < 8; k++) begin
      rq.data[k] = (pattern < 0) ? brb_pkg::byte_t'($urandom) : brb_pkg::byte_t'(pattern);
    end
    return rq;
  endfunction

  function automatic ring_req_t random_req(int push_pct);
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 4) len = 0;
    else if (pick < 10) len = $urandom_range(NUM_LANES + 1, 15);
    else len = $urandom_range(1, NUM_LANES);
    return make_req(($urandom_range(0, 99) < push_pct) ? brb_pkg::REQ_PUSH : brb_pkg::REQ_POP,
                    len, -1);
  endfunction

  function automatic void check_field(string label, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      error_count++;
    end
  endfunction

  task automatic send_item(ring_req_t rq);
    if (rq.req == brb_pkg::REQ_POP && !pop_is_safe(rq.len)) rq.req = brb_pkg::REQ_PUSH;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    ring_outcomes.push_back(apply_ring_request(rq));
    in_valid <= 1'b1;
    in_req_type <= rq.req;
    in_length <= rq.len;
    in_data_in_0 <= rq.data[0];
    in_data_in_1 <= rq.data[1];
    in_data_in_2 <= rq.data[2];
    in_data_in_3 <= rq.data[3];
    in_data_in_4 <= rq.data[4];
    in_data_in_5 <= rq.data[5];
    in_data_in_6 <= rq.data[6];
    in_data_in_7 <= rq.data[7];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (ring_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [brb_pkg::CFG_W-1:0] value);
    quiesce();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_log2_shadow = value;
  endtask

  task automatic test_directed_ops();
    send_item(make_req(brb_pkg::REQ_PUSH, 0, 8'h3C));
    send_item(make_req(brb_pkg::REQ_POP, 0, 0));
    send_item(make_req(brb_pkg::REQ_POP, 1, 0));
    send_item(make_req(brb_pkg::REQ_PUSH, 8, 8'hFF));
    send_item(make_req(brb_pkg::REQ_PUSH, 8, 8'h00));
    send_item(make_req(brb_pkg::REQ_PUSH, 9, 8'h11));
    send_item(make_req(brb_pkg::REQ_PUSH, 15, 8'hFF));
    send_item(make_req(brb_pkg::REQ_POP, 15, 0));
    send_item(make_req(brb_pkg::REQ_POP, 8, 0));
    send_item(make_req(brb_pkg::REQ_POP, 3, 0));
    send_item(make_req(brb_pkg::REQ_POP, 6, 0));
    send_item(make_req(brb_pkg::REQ_POP, 5, 0));
  endtask

  task automatic test_capacity_extremes();
    write_capacity(4'd0);
    send_item(make_req(brb_pkg::REQ_PUSH, 1, 8'h5A));
    send_item(make_req(brb_pkg::REQ_PUSH, 1, 8'hA5));
    send_item(make_req(brb_pkg::REQ_POP, 2, 0));
    send_item(make_req(brb_pkg::REQ_POP, 1, 0));
    send_item(make_req(brb_pkg::REQ_PUSH, 2, 8'h77));
    write_capacity(4'd15);
    send_item(make_req(brb_pkg::REQ_PUSH, 8, -1));
    send_item(make_req(brb_pkg::REQ_POP, 8, 0));
  endtask

  task automatic test_shrink_with_data();
    write_capacity(4'd10);
    send_item(make_req(brb_pkg::REQ_PUSH, 8, -1));
    send_item(make_req(brb_pkg::REQ_PUSH, 8, -1));
    write_capacity(4'd2);
    send_item(make_req(brb_pkg::REQ_PUSH, 1, 8'h99));
    send_item(make_req(brb_pkg::REQ_POP, 8, 0));
    send_item(make_req(brb_pkg::REQ_POP, 8, 0));
    send_item(make_req(brb_pkg::REQ_PUSH, 4, -1));
    send_item(make_req(brb_pkg::REQ_POP, 4, 0));
  endtask

  task automatic test_random_traffic(int count, logic [brb_pkg::CFG_W-1:0] cap, int push_pct,
                                     int gap, int stall);
    write_capacity(cap);
    gap_pct = gap;
    stall_pct = stall;
    repeat (count) send_item(random_req(push_pct));
  endtask

  always @(posedge clk) begin
    int n;
    n = stall_left;
    if (n > 0) n--;
    else if (!quiet && stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
      n = $urandom_range(1, 19);
    stall_left = n;
    out_stall <= (n > 0);
  end

  always @(posedge clk) begin
    ring_result_t want;
    brb_pkg::byte_t got_bytes [8];
    int k;
    if (rst_n && out_valid && !out_stall) begin
      got_bytes = '{out_data_out_0, out_data_out_1, out_data_out_2, out_data_out_3,
                    out_data_out_4, out_data_out_5, out_data_out_6, out_data_out_7};
      if (ring_outcomes.size() == 0) begin
        $display("%0t: result transfer with nothing expected", $time);
        error_count++;
      end else begin
        want = ring_outcomes.pop_front();
        check_field("accepted", want.accepted, out_accepted);
        check_field("fill_level", want.fill, out_fill_level);
        for (k = 0; k < 8; k++) begin
          check_field($sformatf("data_out_%0d", k), want.bytes[k], got_bytes[k]);
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_ops();
    test_capacity_extremes();
    test_shrink_with_data();
    test_random_traffic(150, 4'd10, 70, 10, 10);
    test_random_traffic(300, 4'd10, 90, 5, 5);
    test_random_traffic(150, 4'd10, 30, 15, 15);
    test_random_traffic(150, 4'd0, 50, 10, 10);
    test_random_traffic(150, 4'd15, 60, 0, 20);
    test_random_traffic(150, 4'd1, 50, 20, 0);
    test_random_traffic(150, 4'd3, 60, 10, 10);
    test_random_traffic(150, 4'($urandom_range(0, 15)), 50, 10, 10);
    test_random_traffic(150, 4'd4, 80, 10, 10);
    test_random_traffic(100, 4'd10, 20, 10, 10);
    quiet = 1'b1;
    test_random_traffic(150, 4'd10, 50, 0, 0);
    quiesce();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
